[rtl/circle_contact_solver_defines.svh]
// Assertion macros shared by the contact solver checkers.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CIRCLE_CONTACT_SOLVER_DEFINES_SVH
`define CIRCLE_CONTACT_SOLVER_DEFINES_SVH

// implication checked at every clock edge outside reset
`define CCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication checked at every clock edge, reset included
`define CCS_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/ccs_pkg.sv]
// Constants, types and helpers for the circle contact solver.
// No dependencies; imported by circle_contact_solver, ccs_checker and the testbench.
package ccs_pkg;

    localparam int COORD_W   = 24;
    localparam int RAD_W     = 23;
    localparam int NORM_W    = 16;
    localparam int DEPTH_W   = 25;
    localparam int SQ_W      = 52;
    localparam int DIST_W    = 26;
    localparam int QUO_W     = 15;
    localparam int NUM_W     = 41;
    localparam int SQRT_N    = 26;
    localparam int S_TDATA_W = 240;
    localparam int M_TDATA_W = 160;

    localparam logic [QUO_W-1:0] Q14_ONE = 15'd16384;
    localparam logic signed [26:0] DEPTH_MAX = 27'sd33554431;

    localparam logic [1:0] FACE_LEFT   = 2'd0;
    localparam logic [1:0] FACE_RIGHT  = 2'd1;
    localparam logic [1:0] FACE_TOP    = 2'd2;
    localparam logic [1:0] FACE_BOTTOM = 2'd3;

    typedef struct packed {
        logic                    kind;
        logic                    hit;
        logic                    zero;
        logic signed [23:0]      sx;
        logic signed [23:0]      sy;
        logic signed [23:0]      px;
        logic signed [23:0]      py;
        logic [RAD_W-1:0]        sr;
        logic [RAD_W-1:0]        pr;
        logic signed [24:0]      cx;
        logic signed [24:0]      cy;
        logic [DIST_W-1:0]       dxm;
        logic [DIST_W-1:0]       dym;
        logic                    dxn;
        logic                    dyn;
        logic [1:0]              face;
        logic signed [25:0]      m;
        logic signed [26:0]      depth;
    } t_ctx;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [25:0] v);
        logic [COORD_W-1:0] res;
        if (v > 26'sd8388607) begin
            res = 24'h7FFFFF;
        end else if (v < -26'sd8388608) begin
            res = 24'h800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

endpackage

[rtl/circle_contact_solver.sv]
// Circle contact solver top level: pipelined pair test with sqrt and divide stages.
// Depends on ccs_pkg.
//
// Usage: one pair test enters on the slave stream (tuser = kind, 0 circle partner,
// 1 box partner; tdata = circle and partner geometry). One result leaves on the
// master stream per request, in order (tuser = hit; tdata = normal, depth and
// contact points, all zero on a miss).
// Throughput: one request per cycle while the skid register is empty. The rate is
// set by the 26-stage bit-per-stage square root and the 15-stage restoring divider,
// each fully pipelined.
// Stall: an output register plus a skid register sit at the master side. While
// the skid register is full the whole pipeline holds and o_s_tready is low; no
// request is dropped or repeated.
// Reset: synchronous, active low; clears all stage valid bits and the output and
// skid valid bits. Data registers keep their contents.
module circle_contact_solver
    import ccs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // self_x, self_y, self_radius, partner_x, partner_y, partner_radius,
    // box_min_dx, box_min_dy, box_max_dx, box_max_dy, zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // kind
    input  logic [0:0]           i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // normal_x, normal_y, depth, self_point_x, self_point_y,
    // partner_point_x, partner_point_y, zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // hit
    output logic [0:0]           o_m_tuser
);

    logic w_en;

    // stage 0: input register
    logic                 r0_v, r0_kind;
    logic signed [23:0]   r0_sx, r0_sy, r0_px, r0_py;
    logic signed [23:0]   r0_mindx, r0_mindy, r0_maxdx, r0_maxdy;
    logic [RAD_W-1:0]     r0_sr, r0_pr;

    // stage 1: offsets and circle difference
    logic                 r1_v, r1_kind;
    logic signed [23:0]   r1_sx, r1_sy, r1_px, r1_py;
    logic [RAD_W-1:0]     r1_sr, r1_pr;
    logic signed [24:0]   r1_cdx, r1_cdy, r1_minx, r1_miny, r1_maxx, r1_maxy;
    logic [23:0]          r1_tr;

    // stage 2: clamp and box distances
    logic                 r2_v, r2_kind;
    logic signed [23:0]   r2_sx, r2_sy, r2_px, r2_py;
    logic [RAD_W-1:0]     r2_sr, r2_pr;
    logic signed [24:0]   r2_cx, r2_cy;
    logic signed [25:0]   r2_dx, r2_dy, r2_l, r2_r, r2_t, r2_b;
    logic [23:0]          r2_thr;
    logic signed [24:0]   n2_cx, n2_cy, n2_sx, n2_sy;

    // stage 3: squares and partial minimum
    logic                 r3_v, r3_kind;
    logic signed [23:0]   r3_sx, r3_sy, r3_px, r3_py;
    logic [RAD_W-1:0]     r3_sr, r3_pr;
    logic signed [24:0]   r3_cx, r3_cy;
    logic [DIST_W-1:0]    r3_dxm, r3_dym;
    logic                 r3_dxn, r3_dyn;
    logic [SQ_W-1:0]      r3_sqx, r3_sqy;
    logic [47:0]          r3_thr2;
    logic signed [25:0]   r3_m1, r3_m2, n3_m1, n3_m2;
    logic [1:0]           r3_f1, r3_f2, n3_f1, n3_f2;
    logic [DIST_W-1:0]    n3_dxm, n3_dym;

    // stage 4 onward: square root pipeline
    logic                 r_sq_v   [SQRT_N+1];
    logic [SQ_W-1:0]      r_sq_rem [SQRT_N+1];
    logic [SQ_W-1:0]      r_sq_res [SQRT_N+1];
    t_ctx                 r_sq_ctx [SQRT_N+1];
    logic [SQ_W-1:0]      n4_dsq;
    t_ctx                 n4_ctx;

    // divider pipeline
    logic                 r_dv_v    [QUO_W+1];
    logic [NUM_W-1:0]     r_dv_remx [QUO_W+1];
    logic [NUM_W-1:0]     r_dv_remy [QUO_W+1];
    logic [QUO_W-1:0]     r_dv_qx   [QUO_W+1];
    logic [QUO_W-1:0]     r_dv_qy   [QUO_W+1];
    logic [DIST_W-1:0]    r_dv_dist [QUO_W+1];
    t_ctx                 r_dv_ctx  [QUO_W+1];
    logic [DIST_W-1:0]    n_dist;
    t_ctx                 n_dv_ctx;
    logic signed [26:0]   n_sr27, n_pr27, n_dist27;

    // normal select stage
    logic                 r_nm_v;
    t_ctx                 r_nm_ctx;
    logic [QUO_W-1:0]     r_nxm, r_nym, n_nxm, n_nym;
    logic                 r_nxn, r_nyn, n_nxn, n_nyn;

    // radius multiply stage
    logic                 r_ml_v;
    t_ctx                 r_ml_ctx;
    logic [QUO_W-1:0]     r_ml_nxm, r_ml_nym;
    logic                 r_ml_nxn, r_ml_nyn;
    logic [37:0]          r_ml_sx, r_ml_sy, r_ml_px, r_ml_py;

    // final stage and output
    logic [37:0]          n_rsx, n_rsy, n_rpx, n_rpy;
    logic signed [25:0]   n_tsx, n_tsy, n_tpx, n_tpy;
    logic [COORD_W-1:0]   n_spx, n_spy, n_ppx, n_ppy;
    logic [DEPTH_W-1:0]   n_depth;
    logic signed [NORM_W-1:0] n_nx, n_ny;
    logic [M_TDATA_W-1:0] n_out_data;
    logic                 n_out_hit;
    logic                 r_out_v, r_skid_v, r_out_hit, r_skid_hit;
    logic [M_TDATA_W-1:0] r_out_data, r_skid_data;

    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    // ---------------- stage 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_kind  <= i_s_tuser[0];
            r0_sx    <= i_s_tdata[23:0];
            r0_sy    <= i_s_tdata[47:24];
            r0_sr    <= i_s_tdata[70:48];
            r0_px    <= i_s_tdata[94:71];
            r0_py    <= i_s_tdata[118:95];
            r0_pr    <= i_s_tdata[141:119];
            r0_mindx <= i_s_tdata[165:142];
            r0_mindy <= i_s_tdata[189:166];
            r0_maxdx <= i_s_tdata[213:190];
            r0_maxdy <= i_s_tdata[237:214];
        end
    end

    // ---------------- stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_kind <= r0_kind;
            r1_sx   <= r0_sx;
            r1_sy   <= r0_sy;
            r1_px   <= r0_px;
            r1_py   <= r0_py;
            r1_sr   <= r0_sr;
            r1_pr   <= r0_pr;
            r1_cdx  <= 25'(r0_px) - 25'(r0_sx);
            r1_cdy  <= 25'(r0_py) - 25'(r0_sy);
            r1_minx <= 25'(r0_px) + 25'(r0_mindx);
            r1_miny <= 25'(r0_py) + 25'(r0_mindy);
            r1_maxx <= 25'(r0_px) + 25'(r0_maxdx);
            r1_maxy <= 25'(r0_py) + 25'(r0_maxdy);
            r1_tr   <= 24'(r0_sr) + 24'(r0_pr);
        end
    end

    // ---------------- stage 2: clamp circle centre into the box
    always_comb begin
        n2_sx = 25'(r1_sx);
        n2_sy = 25'(r1_sy);
        if (n2_sx < r1_minx) begin
            n2_cx = r1_minx;
        end else if (n2_sx > r1_maxx) begin
            n2_cx = r1_maxx;
        end else begin
            n2_cx = n2_sx;
        end
        if (n2_sy < r1_miny) begin
            n2_cy = r1_miny;
        end else if (n2_sy > r1_maxy) begin
            n2_cy = r1_maxy;
        end else begin
            n2_cy = n2_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_kind <= r1_kind;
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_sr   <= r1_sr;
            r2_pr   <= r1_pr;
            r2_cx   <= n2_cx;
            r2_cy   <= n2_cy;
            r2_dx   <= r1_kind ? 26'(n2_sx) - 26'(n2_cx) : 26'(r1_cdx);
            r2_dy   <= r1_kind ? 26'(n2_sy) - 26'(n2_cy) : 26'(r1_cdy);
            r2_l    <= 26'(n2_sx) - 26'(r1_minx);
            r2_r    <= 26'(r1_maxx) - 26'(n2_sx);
            r2_t    <= 26'(n2_sy) - 26'(r1_miny);
            r2_b    <= 26'(r1_maxy) - 26'(n2_sy);
            r2_thr  <= r1_kind ? {1'b0, r1_sr} : r1_tr;
        end
    end

    // ---------------- stage 3: squares, nearest face pairs
    always_comb begin
        n3_dxm = r2_dx[25] ? 26'(-r2_dx) : 26'(r2_dx);
        n3_dym = r2_dy[25] ? 26'(-r2_dy) : 26'(r2_dy);
        // ties go to the earlier face
        if (r2_r < r2_l) begin
            n3_m1 = r2_r;
            n3_f1 = FACE_RIGHT;
        end else begin
            n3_m1 = r2_l;
            n3_f1 = FACE_LEFT;
        end
        if (r2_b < r2_t) begin
            n3_m2 = r2_b;
            n3_f2 = FACE_BOTTOM;
        end else begin
            n3_m2 = r2_t;
            n3_f2 = FACE_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_kind <= r2_kind;
            r3_sx   <= r2_sx;
            r3_sy   <= r2_sy;
            r3_px   <= r2_px;
            r3_py   <= r2_py;
            r3_sr   <= r2_sr;
            r3_pr   <= r2_pr;
            r3_cx   <= r2_cx;
            r3_cy   <= r2_cy;
            r3_dxm  <= n3_dxm;
            r3_dym  <= n3_dym;
            r3_dxn  <= r2_dx[25];
            r3_dyn  <= r2_dy[25];
            r3_sqx  <= n3_dxm * n3_dxm;
            r3_sqy  <= n3_dym * n3_dym;
            r3_thr2 <= r2_thr * r2_thr;
            r3_m1   <= n3_m1;
            r3_m2   <= n3_m2;
            r3_f1   <= n3_f1;
            r3_f2   <= n3_f2;
        end
    end

    // ---------------- stage 4: distance squared, hit test, context
    always_comb begin
        n4_dsq       = r3_sqx + r3_sqy;
        n4_ctx       = '0;
        n4_ctx.kind  = r3_kind;
        n4_ctx.hit   = n4_dsq < {4'd0, r3_thr2};
        n4_ctx.zero  = n4_dsq == '0;
        n4_ctx.sx    = r3_sx;
        n4_ctx.sy    = r3_sy;
        n4_ctx.px    = r3_px;
        n4_ctx.py    = r3_py;
        n4_ctx.sr    = r3_sr;
        n4_ctx.pr    = r3_pr;
        n4_ctx.cx    = r3_cx;
        n4_ctx.cy    = r3_cy;
        n4_ctx.dxm   = r3_dxm;
        n4_ctx.dym   = r3_dym;
        n4_ctx.dxn   = r3_dxn;
        n4_ctx.dyn   = r3_dyn;
        if (r3_m2 < r3_m1) begin
            n4_ctx.m    = r3_m2;
            n4_ctx.face = r3_f2;
        end else begin
            n4_ctx.m    = r3_m1;
            n4_ctx.face = r3_f1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_v[0] <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_rem[0] <= n4_dsq;
            r_sq_res[0] <= '0;
            r_sq_ctx[0] <= n4_ctx;
        end
    end

    // ---------------- square root: one result bit per stage
    for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * (SQRT_N - 1 - k));
        logic [SQ_W-1:0] n_trial;
        logic            n_take;

        assign n_trial = r_sq_res[k] + SQ_BIT;
        assign n_take  = r_sq_rem[k] >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[k+1] <= n_take ? r_sq_rem[k] - n_trial : r_sq_rem[k];
                r_sq_res[k+1] <= n_take ? (r_sq_res[k] >> 1) + SQ_BIT : r_sq_res[k] >> 1;
                r_sq_ctx[k+1] <= r_sq_ctx[k];
            end
        end
    end

    // ---------------- divider setup: rounded numerators and raw depth
    always_comb begin
        n_dist   = r_sq_res[SQRT_N][DIST_W-1:0];
        n_sr27   = $signed({4'd0, r_sq_ctx[SQRT_N].sr});
        n_pr27   = $signed({4'd0, r_sq_ctx[SQRT_N].pr});
        n_dist27 = $signed({1'b0, n_dist});
        n_dv_ctx = r_sq_ctx[SQRT_N];
        if (!n_dv_ctx.kind) begin
            n_dv_ctx.depth = n_sr27 + n_pr27 - n_dist27;
        end else if (n_dv_ctx.zero) begin
            n_dv_ctx.depth = n_sr27 + 27'(n_dv_ctx.m);
        end else begin
            n_dv_ctx.depth = n_sr27 - n_dist27;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_v[0] <= r_sq_v[SQRT_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_remx[0] <= {1'b0, r_sq_ctx[SQRT_N].dxm, 14'd0} + NUM_W'(n_dist >> 1);
            r_dv_remy[0] <= {1'b0, r_sq_ctx[SQRT_N].dym, 14'd0} + NUM_W'(n_dist >> 1);
            r_dv_qx[0]   <= '0;
            r_dv_qy[0]   <= '0;
            r_dv_dist[0] <= n_dist;
            r_dv_ctx[0]  <= n_dv_ctx;
        end
    end

    // ---------------- restoring divider: one quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        localparam int SH = QUO_W - 1 - k;
        logic [NUM_W-1:0] n_dsh;
        logic             n_tx, n_ty;

        assign n_dsh = NUM_W'(r_dv_dist[k]) << SH;
        assign n_tx  = r_dv_remx[k] >= n_dsh;
        assign n_ty  = r_dv_remy[k] >= n_dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_remx[k+1] <= n_tx ? r_dv_remx[k] - n_dsh : r_dv_remx[k];
                r_dv_remy[k+1] <= n_ty ? r_dv_remy[k] - n_dsh : r_dv_remy[k];
                r_dv_qx[k+1]   <= r_dv_qx[k] | (QUO_W'(n_tx) << SH);
                r_dv_qy[k+1]   <= r_dv_qy[k] | (QUO_W'(n_ty) << SH);
                r_dv_dist[k+1] <= r_dv_dist[k];
                r_dv_ctx[k+1]  <= r_dv_ctx[k];
            end
        end
    end

    // ---------------- normal select
    always_comb begin
        n_nxm = r_dv_qx[QUO_W];
        n_nym = r_dv_qy[QUO_W];
        n_nxn = r_dv_ctx[QUO_W].dxn;
        n_nyn = r_dv_ctx[QUO_W].dyn;
        if (r_dv_ctx[QUO_W].zero) begin
            n_nxm = '0;
            n_nym = '0;
            n_nxn = 1'b0;
            n_nyn = 1'b0;
            if (!r_dv_ctx[QUO_W].kind) begin
                // coincident centres
                n_nxm = Q14_ONE;
            end else begin
                case (r_dv_ctx[QUO_W].face)
                    FACE_LEFT: begin
                        n_nxm = Q14_ONE;
                    end
                    FACE_RIGHT: begin
                        n_nxm = Q14_ONE;
                        n_nxn = 1'b1;
                    end
                    FACE_TOP: begin
                        n_nym = Q14_ONE;
                    end
                    default: begin
                        n_nym = Q14_ONE;
                        n_nyn = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_v <= 1'b0;
        end else if (w_en) begin
            r_nm_v <= r_dv_v[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nm_ctx <= r_dv_ctx[QUO_W];
            r_nxm    <= n_nxm;
            r_nym    <= n_nym;
            r_nxn    <= n_nxn;
            r_nyn    <= n_nyn;
        end
    end

    // ---------------- normal times radius
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ml_v <= 1'b0;
        end else if (w_en) begin
            r_ml_v <= r_nm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ml_ctx <= r_nm_ctx;
            r_ml_nxm <= r_nxm;
            r_ml_nym <= r_nym;
            r_ml_nxn <= r_nxn;
            r_ml_nyn <= r_nyn;
            r_ml_sx  <= r_nxm * r_nm_ctx.sr;
            r_ml_sy  <= r_nym * r_nm_ctx.sr;
            r_ml_px  <= r_nxm * r_nm_ctx.pr;
            r_ml_py  <= r_nym * r_nm_ctx.pr;
        end
    end

    // ---------------- round, offset, saturate
    always_comb begin
        n_rsx = r_ml_sx + 38'd8192;
        n_rsy = r_ml_sy + 38'd8192;
        n_rpx = r_ml_px + 38'd8192;
        n_rpy = r_ml_py + 38'd8192;
        n_tsx = r_ml_nxn ? -$signed({2'd0, n_rsx[37:14]}) : $signed({2'd0, n_rsx[37:14]});
        n_tsy = r_ml_nyn ? -$signed({2'd0, n_rsy[37:14]}) : $signed({2'd0, n_rsy[37:14]});
        n_tpx = r_ml_nxn ? -$signed({2'd0, n_rpx[37:14]}) : $signed({2'd0, n_rpx[37:14]});
        n_tpy = r_ml_nyn ? -$signed({2'd0, n_rpy[37:14]}) : $signed({2'd0, n_rpy[37:14]});
        n_nx  = r_ml_nxn ? -$signed({1'b0, r_ml_nxm}) : $signed({1'b0, r_ml_nxm});
        n_ny  = r_ml_nyn ? -$signed({1'b0, r_ml_nym}) : $signed({1'b0, r_ml_nym});

        if (!r_ml_ctx.kind) begin
            n_spx = sat_coord(26'(r_ml_ctx.sx) + n_tsx);
            n_spy = sat_coord(26'(r_ml_ctx.sy) + n_tsy);
            n_ppx = sat_coord(26'(r_ml_ctx.px) - n_tpx);
            n_ppy = sat_coord(26'(r_ml_ctx.py) - n_tpy);
        end else if (r_ml_ctx.zero) begin
            n_spx = sat_coord(26'(r_ml_ctx.sx) - n_tsx);
            n_spy = sat_coord(26'(r_ml_ctx.sy) - n_tsy);
            n_ppx = n_spx;
            n_ppy = n_spy;
        end else begin
            n_spx = sat_coord(26'(r_ml_ctx.cx));
            n_spy = sat_coord(26'(r_ml_ctx.cy));
            n_ppx = n_spx;
            n_ppy = n_spy;
        end

        if (r_ml_ctx.depth < 27'sd0) begin
            n_depth = '0;
        end else if (r_ml_ctx.depth > DEPTH_MAX) begin
            n_depth = DEPTH_MAX[DEPTH_W-1:0];
        end else begin
            n_depth = r_ml_ctx.depth[DEPTH_W-1:0];
        end

        n_out_hit = r_ml_ctx.hit;
        // drop everything but the hit flag on a miss
        if (r_ml_ctx.hit) begin
            n_out_data = {7'd0, n_ppy, n_ppx, n_spy, n_spx, n_depth, n_ny, n_nx};
        end else begin
            n_out_data = '0;
        end
    end

    // ---------------- output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v) begin
            if (r_out_v && !i_m_tready) begin
                r_skid_v <= r_ml_v;
            end else begin
                r_out_v <= r_ml_v;
            end
        end else if (i_m_tready) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            if (r_out_v && !i_m_tready) begin
                r_skid_data <= n_out_data;
                r_skid_hit  <= n_out_hit;
            end else begin
                r_out_data <= n_out_data;
                r_out_hit  <= n_out_hit;
            end
        end else if (i_m_tready) begin
            r_out_data <= r_skid_data;
            r_out_hit  <= r_skid_hit;
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_hit;

endmodule

[rtl/ccs_checker.sv]
// Port-level checks for circle_contact_solver, bound to the top level.
// Depends on ccs_pkg and circle_contact_solver_defines.svh.
`include "circle_contact_solver_defines.svh"

module ccs_checker
    import ccs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [0:0]           o_m_tuser
);

    // hold a result until it is taken
    `CCS_ASSERT(a_hold_valid, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")

    // a miss carries no geometry
    `CCS_ASSERT(a_miss_zero, o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == '0, "miss with nonzero fields")

    // a hit always has a nonzero normal
    `CCS_ASSERT(a_hit_normal, o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[31:0] != 32'd0, "hit with zero normal")

    // pad bits stay clear
    `CCS_ASSERT(a_pad_zero, o_m_tvalid |-> o_m_tdata[159:153] == 7'd0, "tdata pad bits set")

    // reset empties the output side and opens the input
    `CCS_ASSERT_ANY(a_reset_idle, !i_rst_n |=> !o_m_tvalid && o_s_tready, "not idle after reset")

endmodule

bind circle_contact_solver ccs_checker u_ccs_checker (.*);

[tb/sv/circle_contact_solver_tb.sv]
// Testbench for circle_contact_solver: drives pair tests on the slave stream and
// checks every result against an in-bench predictor. Depends on ccs_pkg and the RTL.
module circle_contact_solver_tb;
    import ccs_pkg::*;

    localparam logic KIND_CIRCLE = 1'b0;
    localparam logic KIND_BOX    = 1'b1;
    localparam longint ONE_Q14   = 16384;
    localparam longint CMAX      = 8388607;
    localparam longint CMIN      = -8388608;
    localparam longint DMAX      = 33554431;

    typedef struct {
        logic        kind;
        logic [23:0] sx, sy;
        logic [22:0] sr;
        logic [23:0] px, py;
        logic [22:0] pr;
        logic [23:0] mindx, mindy, maxdx, maxdy;
    } t_pair;

    typedef struct {
        logic        hit;
        logic [15:0] nx, ny;
        logic [24:0] depth;
        logic [23:0] spx, spy, ppx, ppy;
    } t_contact;

    function automatic longint iroot(longint v);
        longint res, bit_v;
        res = 0;
        bit_v = 64'sd1 <<< 62;
        while (bit_v > v) bit_v = bit_v >>> 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v = v - res - bit_v;
                res = (res >>> 1) + bit_v;
            end else begin
                res = res >>> 1;
            end
            bit_v = bit_v >>> 2;
        end
        return res;
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unit_part(longint d, longint dlen);
        longint q;
        q = (absl(d) * ONE_Q14 + dlen / 2) / dlen;
        return d < 0 ? -q : q;
    endfunction

    function automatic longint scale_rad(longint n, longint r);
        longint q;
        q = (absl(n) * r + 8192) >>> 14;
        return n < 0 ? -q : q;
    endfunction

    function automatic longint satc(longint v);
        return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_contact predict_contact(t_pair p);
        t_contact c;
        longint sx, sy, sr, px, py, pr, nx, ny, dep, spx, spy, ppx, ppy;
        longint dx, dy, dsq, tr, dlen, minx, miny, maxx, maxy, cx, cy;
        longint l, r, t, b, m;
        sx = longint'($signed(p.sx)); sy = longint'($signed(p.sy));
        px = longint'($signed(p.px)); py = longint'($signed(p.py));
        sr = longint'(p.sr); pr = longint'(p.pr);
        nx = 0; ny = 0; dep = 0; spx = 0; spy = 0; ppx = 0; ppy = 0;
        c.hit = 1'b0;
        if (p.kind == KIND_CIRCLE) begin
            dx = px - sx; dy = py - sy;
            dsq = dx * dx + dy * dy;
            tr = sr + pr;
            if (dsq < tr * tr) begin
                dlen = iroot(dsq);
                c.hit = 1'b1;
                dep = tr - dlen;
                if (dlen == 0) begin
                    nx = ONE_Q14;
                end else begin
                    nx = unit_part(dx, dlen); ny = unit_part(dy, dlen);
                end
                spx = satc(sx + scale_rad(nx, sr)); spy = satc(sy + scale_rad(ny, sr));
                ppx = satc(px - scale_rad(nx, pr)); ppy = satc(py - scale_rad(ny, pr));
            end
        end else begin
            minx = px + longint'($signed(p.mindx)); miny = py + longint'($signed(p.mindy));
            maxx = px + longint'($signed(p.maxdx)); maxy = py + longint'($signed(p.maxdy));
            cx = clampv(sx, minx, maxx); cy = clampv(sy, miny, maxy);
            dx = sx - cx; dy = sy - cy;
            dsq = dx * dx + dy * dy;
            if (dsq < sr * sr) begin
                c.hit = 1'b1;
                if (dsq == 0) begin
                    l = sx - minx; r = maxx - sx; t = sy - miny; b = maxy - sy;
                    m = l;
                    if (r < m) m = r;
                    if (t < m) m = t;
                    if (b < m) m = b;
                    if (m == l) nx = ONE_Q14;
                    else if (m == r) nx = -ONE_Q14;
                    else if (m == t) ny = ONE_Q14;
                    else ny = -ONE_Q14;
                    dep = sr + m;
                    spx = satc(sx - scale_rad(nx, sr)); spy = satc(sy - scale_rad(ny, sr));
                end else begin
                    dlen = iroot(dsq);
                    nx = unit_part(dx, dlen); ny = unit_part(dy, dlen);
                    dep = sr - dlen;
                    spx = satc(cx); spy = satc(cy);
                end
                ppx = spx; ppy = spy;
            end
        end
        if (dep > DMAX) dep = DMAX;
        if (dep < 0) dep = 0;
        c.nx = nx[15:0]; c.ny = ny[15:0]; c.depth = dep[24:0];
        c.spx = spx[23:0]; c.spy = spy[23:0]; c.ppx = ppx[23:0]; c.ppy = ppy[23:0];
        return c;
    endfunction

    class contact_scoreboard;
        t_contact pending[$];
        int       errors;

        function void note_request(t_pair p);
            pending.push_back(predict_contact(p));
        endfunction

        function void check_result(logic hit, logic [M_TDATA_W-1:0] d);
            t_contact e;
            t_contact a;
            if (pending.size() == 0) begin
                $error("result with no request pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            a.hit = hit;
            {a.ppy, a.ppx, a.spy, a.spx, a.depth, a.ny, a.nx} = d[152:0];
            if (a.hit !== e.hit) begin
                $error("hit exp %0h got %0h", e.hit, a.hit); errors++;
            end
            if (a.nx !== e.nx) begin
                $error("normal_x exp %0h got %0h", e.nx, a.nx); errors++;
            end
            if (a.ny !== e.ny) begin
                $error("normal_y exp %0h got %0h", e.ny, a.ny); errors++;
            end
            if (a.depth !== e.depth) begin
                $error("depth exp %0h got %0h", e.depth, a.depth); errors++;
            end
            if (a.spx !== e.spx) begin
                $error("self_point_x exp %0h got %0h", e.spx, a.spx); errors++;
            end
            if (a.spy !== e.spy) begin
                $error("self_point_y exp %0h got %0h", e.spy, a.spy); errors++;
            end
            if (a.ppx !== e.ppx) begin
                $error("partner_point_x exp %0h got %0h", e.ppx, a.ppx); errors++;
            end
            if (a.ppy !== e.ppy) begin
                $error("partner_point_y exp %0h got %0h", e.ppy, a.ppy); errors++;
            end
            if (d[159:153] !== 7'd0) begin
                $error("tdata pad exp 0 got %0h", d[159:153]); errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    contact_scoreboard scb;
    bit                stim_done;
    bit                hold_off;

    circle_contact_solver u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [23:0] rnd_coord(int span);
        case ($urandom_range(0, 5))
            0:       return 24'($urandom);
            1:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($urandom_range(0, 2 * span) - span);
        endcase
    endfunction

    function automatic t_pair rnd_pair();
        t_pair p;
        int span;
        span = $urandom_range(0, 3) == 0 ? 8000000 : 4000;
        p.kind  = 1'($urandom_range(0, 1));
        p.sx    = rnd_coord(span); p.sy = rnd_coord(span);
        p.sr    = $urandom_range(0, 7) == 0 ? 23'($urandom) : 23'($urandom_range(0, span));
        p.px    = $urandom_range(0, 3) == 0 ? rnd_coord(span)
                                            : p.sx + 24'($urandom_range(0, span) - span / 2);
        p.py    = $urandom_range(0, 3) == 0 ? rnd_coord(span)
                                            : p.sy + 24'($urandom_range(0, span) - span / 2);
        p.pr    = $urandom_range(0, 7) == 0 ? 23'($urandom) : 23'($urandom_range(0, span));
        p.mindx = $urandom_range(0, 9) == 0 ? rnd_coord(span) : -24'($urandom_range(0, span));
        p.mindy = $urandom_range(0, 9) == 0 ? rnd_coord(span) : -24'($urandom_range(0, span));
        p.maxdx = $urandom_range(0, 9) == 0 ? rnd_coord(span) : 24'($urandom_range(0, span));
        p.maxdy = $urandom_range(0, 9) == 0 ? rnd_coord(span) : 24'($urandom_range(0, span));
        if ($urandom_range(0, 4) == 0) p.px = p.sx;
        if ($urandom_range(0, 4) == 0) p.py = p.sy;
        return p;
    endfunction

    function automatic t_pair mk_pair(logic kind, int sx, int sy, int sr, int px, int py,
                                      int pr, int a, int b, int c, int d);
        t_pair p;
        p.kind = kind; p.sx = 24'(sx); p.sy = 24'(sy); p.sr = 23'(sr);
        p.px = 24'(px); p.py = 24'(py); p.pr = 23'(pr);
        p.mindx = 24'(a); p.mindy = 24'(b); p.maxdx = 24'(c); p.maxdy = 24'(d);
        return p;
    endfunction

    task automatic send_request(t_pair p, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= p.kind;
        s_tdata  <= {2'd0, p.maxdy, p.maxdx, p.mindy, p.mindx, p.pr, p.py, p.px,
                     p.sr, p.sy, p.sx};
        do @(posedge i_clk); while (!s_tready);
        scb.note_request(p);
    endtask

    // sink: random stall per result, long hold-off on request
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 1)) stall = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            if (m_tvalid) scb.check_result(m_tuser[0], m_tdata);
        end
    end

    initial begin
        t_pair dir[$];
        bit burst;
        scb = new();
        stim_done = 1'b0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // circle partner: overlap, miss, coincident centres, extremes
        dir.push_back(mk_pair(KIND_CIRCLE, 0, 0, 512, 256, 256, 512, 0, 0, 0, 0));
        dir.push_back(mk_pair(KIND_CIRCLE, 0, 0, 100, 5000, 0, 100, 0, 0, 0, 0));
        dir.push_back(mk_pair(KIND_CIRCLE, 77, -9, 300, 77, -9, 200, 0, 0, 0, 0));
        dir.push_back(mk_pair(KIND_CIRCLE, 8388607, 8388607, 8388607, -8388608, -8388608,
                              8388607, 0, 0, 0, 0));
        dir.push_back(mk_pair(KIND_CIRCLE, -8388608, 0, 8388607, -8388608, 0, 8388607,
                              0, 0, 0, 0));
        dir.push_back(mk_pair(KIND_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk_pair(KIND_CIRCLE, 8388000, 0, 8388607, 8388607, 1, 5, 0, 0, 0, 0));
        // box partner: each nearest face, ties, outside, inverted, miss, extremes
        dir.push_back(mk_pair(KIND_BOX, -90, 0, 50, 0, 0, 0, -100, -100, 100, 100));
        dir.push_back(mk_pair(KIND_BOX, 90, 0, 50, 0, 0, 0, -100, -100, 100, 100));
        dir.push_back(mk_pair(KIND_BOX, 0, -90, 50, 0, 0, 0, -100, -100, 100, 100));
        dir.push_back(mk_pair(KIND_BOX, 0, 90, 50, 0, 0, 0, -100, -100, 100, 100));
        dir.push_back(mk_pair(KIND_BOX, 0, 0, 50, 0, 0, 0, -100, -100, 100, 100));
        dir.push_back(mk_pair(KIND_BOX, 130, 120, 60, 0, 0, 0, -100, -100, 100, 100));
        dir.push_back(mk_pair(KIND_BOX, 300, 0, 60, 0, 0, 0, -100, -100, 100, 100));
        dir.push_back(mk_pair(KIND_BOX, 0, 0, 400, 0, 0, 0, 100, 100, -100, -100));
        dir.push_back(mk_pair(KIND_BOX, 8388607, -8388608, 8388607, 8388607, 8388607, 0,
                              8388607, -8388608, -8388608, 8388607));
        dir.push_back(mk_pair(KIND_BOX, -8388608, 8388607, 8388607, -8388608, -8388608, 0,
                              -8388608, -8388608, 8388607, 8388607));
        dir.push_back(mk_pair(KIND_BOX, 0, 0, 8388607, 0, 0, 8388607, -8388608, -8388608,
                              8388607, 8388607));
        dir.push_back(mk_pair(KIND_BOX, 10, 10, 0, 0, 0, 0, -100, -100, 100, 100));
        foreach (dir[i]) send_request(dir[i], 1'b0);
        for (int n = 0; n < 540; n++) begin
            if (n == 200) hold_off = 1'b1;
            burst = (n >= 200 && n < 300) || (n % 97 < 15);
            send_request(rnd_pair(), burst);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        @(posedge i_clk iff stim_done);
        while (scb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (scb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
